// File: rtl/lbp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_pkg
// shared codes and controller/datapath command and status types for the
// lsb-first bit packer
// ----------------------------------------------------------------------------
package lbp_pkg;

    // operation codes carried in s_tuser
    localparam logic [1:0] MODE_PUSH_BITS = 2'd0;
    localparam logic [1:0] MODE_PUSH_WORD = 2'd1;
    localparam logic [1:0] MODE_CLEAR     = 2'd2;
    localparam logic [1:0] MODE_READ      = 2'd3;

    // result status codes carried in m_tuser
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_WIDE     = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;   // latch the incoming transfer
        logic decode;    // evaluate the operation, update position
        logic write;     // write one byte from the staging buffer
        logic out_load;  // load the result register
    } dp_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic wr_done;   // no byte writes left
    } dp_sts_t;

endpackage
`default_nettype wire

// File: rtl/lsb_first_bit_packer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsb_first_bit_packer_top
// packs values lsb first into a byte store and reads bytes back
// ----------------------------------------------------------------------------
// usage:
//   each s_ transfer is one operation selected by s_tuser: push bit_count
//   low bits of value, push an aligned 32-bit little-endian word, clear the
//   store, or read one byte. each operation returns exactly one m_ transfer
//   with the status, the used length in bytes and the read byte.
// operation sequence:
//   one operation at a time. a transfer passes an accept state, a decode
//   state, one byte write per byte in the write state (0 to 5, bits plus
//   partial byte; 4 for a word), a write-state check that closes the write
//   loop and a finish state that loads the result register.
//   the byte store has a single write port, so bytes are written one at a time.
// stalls:
//   the result sits in an output register; a new transfer is accepted while
//   it waits, and the sequencer holds in its final cycle until m_tready
//   frees the register.
// reset:
//   aresetn clears the bit position, so the store reads as empty at once;
//   bytes at or above the used length read as zero. no clearing pass.
// ----------------------------------------------------------------------------
module lsb_first_bit_packer_top #(
    parameter int BUFFER_BYTES = 1024
) (
    input  wire         aclk,
    input  wire         aresetn,
    // input channel
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [47:0]  s_tdata,   // value[31:0], bit_count[37:32], read_address[47:38]
    input  wire [1:0]   s_tuser,   // mode[1:0]
    // result channel
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata,   // length_bytes[10:0], read_byte[18:11], zero[23:19]
    output logic [1:0]  m_tuser    // status[1:0]
);
    import lbp_pkg::*;

    dp_cmd_t     cmd;
    dp_sts_t     sts;
    logic [10:0] length_bytes;
    logic [7:0]  read_byte;

    // sequencer
    lbp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // position, store and result register
    lbp_datapath #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .in_mode          (s_tuser),
        .in_value         (s_tdata[31:0]),
        .in_bit_count     (s_tdata[37:32]),
        .in_read_address  (s_tdata[47:38]),
        .out_status       (m_tuser),
        .out_length_bytes (length_bytes),
        .out_read_byte    (read_byte)
    );

    assign m_tdata = {5'd0, read_byte, length_bytes};

`ifndef SYNTHESIS
    // one operation at a time: no accept right after an accept
    a_single_op: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("transfer accepted while an operation is in flight");

    // status code is never the unused value
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_WIDE || m_tuser == ST_OVERFLOW))
        else $error("unused status code on result");

    // only reads return data, and reads always report ok
    a_read_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_OK) |-> (read_byte == 8'd0))
        else $error("read byte set on a failed push");

    // byte writes only happen while the sequencer is busy
    a_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.write |-> !s_tready)
        else $error("byte write while idle");
`endif

endmodule
`default_nettype wire

// File: rtl/lbp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_ctrl
// sequencing state machine: accept, decode, byte writes, result hand-off
// ----------------------------------------------------------------------------
module lbp_ctrl (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  wire              m_tready,
    output lbp_pkg::dp_cmd_t cmd,
    input  lbp_pkg::dp_sts_t sts
);
    import lbp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_WRITE,
        S_FINISH
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb begin
        cmd.capture  = (state_reg == S_IDLE) && s_tvalid;
        cmd.decode   = (state_reg == S_DECODE);
        cmd.write    = (state_reg == S_WRITE) && !sts.wr_done;
        cmd.out_load = (state_reg == S_FINISH) && (!out_valid_reg || m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            // result register drains independently of the sequencer,
            // a new load in the same cycle keeps it full
            if ((state_reg == S_FINISH) && (!out_valid_reg || m_tready)) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    state_reg <= S_WRITE;
                end
                S_WRITE: begin
                    if (sts.wr_done) begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (!out_valid_reg || m_tready) begin
                        state_reg <= S_IDLE;
                    end
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// File: rtl/lbp_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_datapath
// bit position, partial byte, staging buffer, byte store and result register
// ----------------------------------------------------------------------------
module lbp_datapath #(
    parameter int BUFFER_BYTES = 1024
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  lbp_pkg::dp_cmd_t cmd,
    output lbp_pkg::dp_sts_t sts,
    input  wire [1:0]        in_mode,
    input  wire [31:0]       in_value,
    input  wire [5:0]        in_bit_count,
    input  wire [9:0]        in_read_address,
    output logic [1:0]       out_status,
    output logic [10:0]      out_length_bytes,
    output logic [7:0]       out_read_byte
);
    import lbp_pkg::*;

    localparam int AW   = $clog2(BUFFER_BYTES);
    localparam int UW   = $clog2(BUFFER_BYTES + 1);
    localparam int PW   = UW + 3;
    localparam int CMPW = (UW > 10) ? UW : 10;
    localparam logic [PW-1:0] CAP_BITS  = PW'(BUFFER_BYTES * 8);
    localparam logic [UW:0]   CAP_BYTES = (UW+1)'(BUFFER_BYTES);

    // latched transfer
    logic [1:0]  mode_reg;
    logic [31:0] value_reg;
    logic [5:0]  count_reg;
    logic [9:0]  addr_reg;

    // write state; bits at or above the position are always zero
    logic [PW-1:0] pos_reg;
    logic [7:0]    part_reg;
    logic [39:0]   buf_reg;
    logic [AW-1:0] wr_addr_reg;
    logic [2:0]    wr_cnt_reg;
    logic [1:0]    status_reg;
    logic          rd_hit_reg;
    logic [7:0]    rd_q_reg;

    logic [1:0]  out_status_reg;
    logic [10:0] out_len_reg;
    logic [7:0]  out_rbyte_reg;

    logic [7:0] mem [BUFFER_BYTES];

    // position derived values
    logic [2:0]    ofs;
    logic [UW-1:0] byte_idx;
    logic [UW-1:0] used;
    logic [31:0]   used_ext;

    // bit push path
    logic [5:0]    cnt_c;
    logic [31:0]   shifted;
    logic          wide;
    logic [PW-1:0] avail;
    logic          ovf_bits;
    logic [5:0]    n;
    logic [31:0]   vmask;
    logic [39:0]   buf_push;
    logic [5:0]    tot;
    logic [6:0]    tot_rnd;
    logic [39:0]   buf_hi;
    logic [PW-1:0] pos_push;

    // word push path
    logic [UW:0]     word_end;
    logic            word_ovf;
    logic [UW-1:0]   word_start_next;

    // read path
    logic [CMPW-1:0] addr_ext;
    logic            rd_hit;

    // decode results
    logic [1:0]    dec_status;
    logic [PW-1:0] dec_pos;
    logic [7:0]    dec_part;
    logic [39:0]   dec_buf;
    logic [AW-1:0] dec_wr_addr;
    logic [2:0]    dec_wr_cnt;
    logic          dec_rd_hit;

    always_comb begin
        ofs      = pos_reg[2:0];
        byte_idx = pos_reg[PW-1:3];
        used     = byte_idx + UW'(ofs != 3'd0);
        used_ext = 32'(used);

        cnt_c    = (count_reg > 6'd32) ? 6'd32 : count_reg;
        shifted  = value_reg >> cnt_c;
        wide     = (cnt_c != 6'd32) && !value_reg[31] && (shifted != 32'd0);
        avail    = CAP_BITS - pos_reg;
        ovf_bits = PW'(cnt_c) > avail;
        n        = ovf_bits ? avail[5:0] : cnt_c;
        vmask    = (n == 6'd0) ? 32'd0 : (value_reg & (32'hFFFF_FFFF >> (6'd32 - n)));
        buf_push = ({8'd0, vmask} << ofs) | {32'd0, part_reg};
        tot      = n + 6'(ofs);
        tot_rnd  = 7'(tot) + 7'd7;
        buf_hi   = buf_push >> {tot[5:3], 3'b000};
        pos_push = pos_reg + PW'(n);

        word_end        = {1'b0, used} + (UW+1)'(4);
        word_ovf        = word_end > CAP_BYTES;
        word_start_next = used + UW'(4);

        addr_ext = CMPW'(addr_reg);
        rd_hit   = addr_ext < CMPW'(used);
    end

    always_comb begin
        dec_status  = ST_OK;
        dec_pos     = pos_reg;
        dec_part    = part_reg;
        dec_buf     = buf_push;
        dec_wr_addr = byte_idx[AW-1:0];
        dec_wr_cnt  = 3'd0;
        dec_rd_hit  = 1'b0;
        unique case (mode_reg)
            MODE_PUSH_BITS: begin
                if (wide) begin
                    dec_status = ST_WIDE;
                end else begin
                    dec_status = ovf_bits ? ST_OVERFLOW : ST_OK;
                    dec_pos    = pos_push;
                    dec_part   = buf_hi[7:0];
                    dec_wr_cnt = tot_rnd[5:3];
                end
            end
            MODE_PUSH_WORD: begin
                if (word_ovf) begin
                    dec_status = ST_OVERFLOW;
                end else begin
                    dec_pos     = {word_start_next, 3'b000};
                    dec_part    = 8'd0;
                    dec_buf     = {8'd0, value_reg};
                    dec_wr_addr = used[AW-1:0];
                    dec_wr_cnt  = 3'd4;
                end
            end
            MODE_CLEAR: begin
                dec_pos  = '0;
                dec_part = 8'd0;
            end
            MODE_READ: begin
                dec_rd_hit = rd_hit;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            part_reg   <= 8'd0;
            wr_cnt_reg <= 3'd0;
        end else begin
            if (cmd.decode) begin
                pos_reg    <= dec_pos;
                part_reg   <= dec_part;
                wr_cnt_reg <= dec_wr_cnt;
            end else if (cmd.write) begin
                wr_cnt_reg <= wr_cnt_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg  <= in_mode;
            value_reg <= in_value;
            count_reg <= in_bit_count;
            addr_reg  <= in_read_address;
        end
        if (cmd.decode) begin
            status_reg  <= dec_status;
            rd_hit_reg  <= dec_rd_hit;
            buf_reg     <= dec_buf;
            wr_addr_reg <= dec_wr_addr;
        end else if (cmd.write) begin
            buf_reg     <= buf_reg >> 8;
            wr_addr_reg <= wr_addr_reg + AW'(1);
        end
        if (cmd.out_load) begin
            out_status_reg <= status_reg;
            out_len_reg    <= used_ext[10:0];
            out_rbyte_reg  <= rd_hit_reg ? rd_q_reg : 8'd0;
        end
    end

    // byte store, one write port and one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.write) begin
            mem[wr_addr_reg] <= buf_reg[7:0];
        end
        if (cmd.decode) begin
            rd_q_reg <= mem[addr_ext[AW-1:0]];
        end
    end

    assign sts.wr_done      = (wr_cnt_reg == 3'd0);
    assign out_status       = out_status_reg;
    assign out_length_bytes = out_len_reg;
    assign out_read_byte    = out_rbyte_reg;

endmodule
`default_nettype wire

// File: sim/lsb_first_bit_packer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lsb_first_bit_packer_checker
// keeps its own copy of the byte store and bit position, works out the reply
// to every accepted input transfer and compares result transfers in order
// ----------------------------------------------------------------------------
module lsb_first_bit_packer_checker #(
    parameter int BUFFER_BYTES = 1024
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire [47:0]  s_tdata,   // value[31:0], bit_count[37:32], read_address[47:38]
    input  wire [1:0]   s_tuser,   // mode[1:0]
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire [23:0]  m_tdata,   // length_bytes[10:0], read_byte[18:11], zero[23:19]
    input  wire [1:0]   m_tuser,   // status[1:0]
    output int          fail_count,
    output int          replies_owed
);
    import lbp_pkg::*;

    localparam int CAP_BITS = BUFFER_BYTES * 8;

    typedef struct packed {
        logic [1:0]  status;
        logic [10:0] length_bytes;
        logic [7:0]  read_byte;
    } reply_t;

    logic [7:0]  store_copy [BUFFER_BYTES];
    int unsigned write_bit;
    reply_t      owed_replies [$];
    int          mismatches = 0;

    function automatic void wipe_store();
        for (int i = 0; i < BUFFER_BYTES; i++) store_copy[i] = 8'h00;
        write_bit = 0;
    endfunction

    function automatic logic [1:0] append_bits(logic [31:0] value, logic [5:0] count);
        int unsigned n;
        n = (count > 6'd32) ? 32 : count;
        // a non-negative value must fit the bit count, a negative one is cut
        if (n < 32 && !value[31] && (value >> n) != 32'd0) return ST_WIDE;
        for (int i = 0; i < n; i++) begin
            if (write_bit >= CAP_BITS) return ST_OVERFLOW;
            store_copy[write_bit >> 3][write_bit & 7] = value[i];
            write_bit++;
        end
        return ST_OK;
    endfunction

    function automatic logic [1:0] append_word(logic [31:0] value);
        int unsigned start;
        start = (write_bit + 7) >> 3;
        if (start + 4 > BUFFER_BYTES) return ST_OVERFLOW;
        for (int k = 0; k < 4; k++) store_copy[start + k] = value[8*k +: 8];
        write_bit = (start + 4) * 8;
        return ST_OK;
    endfunction

    function automatic reply_t predict_reply(logic [1:0] mode, logic [31:0] value,
                                             logic [5:0] count, logic [9:0] addr);
        reply_t r;
        r = '0;
        case (mode)
            MODE_PUSH_BITS: r.status = append_bits(value, count);
            MODE_PUSH_WORD: r.status = append_word(value);
            MODE_CLEAR:     wipe_store();
            default: begin
                if (addr < BUFFER_BYTES) r.read_byte = store_copy[addr];
            end
        endcase
        r.length_bytes = 11'((write_bit + 7) >> 3);
        return r;
    endfunction

    task automatic check_reply(reply_t got, logic [4:0] pad);
        reply_t want;
        if (owed_replies.size() == 0) begin
            $display("%0t: result transfer with none expected, got status %0d length %0d byte %02h",
                     $time, got.status, got.length_bytes, got.read_byte);
            mismatches++;
            return;
        end
        want = owed_replies.pop_front();
        if (got.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
            mismatches++;
        end
        if (got.length_bytes !== want.length_bytes) begin
            $display("%0t: length_bytes expected %0d, got %0d",
                     $time, want.length_bytes, got.length_bytes);
            mismatches++;
        end
        if (got.read_byte !== want.read_byte) begin
            $display("%0t: read_byte expected %02h, got %02h",
                     $time, want.read_byte, got.read_byte);
            mismatches++;
        end
        if (pad !== 5'd0) begin
            $display("%0t: tdata padding expected 00, got %02h", $time, pad);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            wipe_store();
            owed_replies.delete();
            mismatches = 0;
            fail_count <= 0;
            replies_owed <= 0;
        end else begin
            // a reply never comes in the cycle of its own request
            if (m_tvalid && m_tready)
                check_reply('{status: m_tuser, length_bytes: m_tdata[10:0],
                              read_byte: m_tdata[18:11]}, m_tdata[23:19]);
            if (s_tvalid && s_tready)
                owed_replies.push_back(predict_reply(s_tuser, s_tdata[31:0],
                                                     s_tdata[37:32], s_tdata[47:38]));
            fail_count <= mismatches;
            replies_owed <= owed_replies.size();
        end
    end

endmodule

// File: sim/lsb_first_bit_packer_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lsb_first_bit_packer_top_test
// drives pushes, word pushes, clears and reads into the packer under several
// idle and stall patterns; the checker predicts and compares every reply
// ----------------------------------------------------------------------------
module lsb_first_bit_packer_top_test;
    import lbp_pkg::*;

    localparam int BUFFER_BYTES    = 1024;
    localparam int CAP_BITS        = BUFFER_BYTES * 8;
    localparam int QUIET_LIMIT     = 5000;   // cycles with no transfer on either side
    localparam int MIXED_PER_PHASE = 100;
    localparam int TAIL_CYCLES     = 20;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [47:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = MODE_PUSH_BITS;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [23:0] m_tdata;
    wire  [1:0]  m_tuser;
    int          fail_count;
    int          replies_owed;

    // idle and stall odds in percent, changed per phase
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    // rough bit position as the generator sees it, only used to aim reads
    // and to know when the store is full
    int unsigned fill_est      = 0;
    int unsigned sent_items    = 0;
    int unsigned quiet_cycles  = 0;

    always #5 aclk = ~aclk;

    lsb_first_bit_packer_top #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    lsb_first_bit_packer_checker #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) reply_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .replies_owed (replies_owed)
    );

    // receiver side: stall at random, odds set by the current phase
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // watchdog: a long stretch without any transfer means a hang
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("[lsb_first_bit_packer_top] ERROR");
            $finish;
        end
    end

    // one input transfer, with random idle cycles ahead of it
    task automatic send_op(input logic [1:0] mode, input logic [31:0] value,
                           input logic [5:0] count, input logic [9:0] addr);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {addr, count, value};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_items++;
    endtask

    function automatic void track_bits(int unsigned n);
        fill_est = (fill_est + n > CAP_BITS) ? CAP_BITS : fill_est + n;
    endfunction

    // push that passes the width check: value masked to the count, or
    // negative so that only its low bits are taken
    task automatic push_shaped(input int unsigned lo, input int unsigned hi);
        int unsigned n;
        logic [31:0] v;
        logic [63:0] keep;
        n    = $urandom_range(hi, lo);
        v    = $urandom;
        keep = (64'd1 << n) - 64'd1;
        if (n < 32) begin
            if ($urandom_range(3) == 0) v[31] = 1'b1;
            else v = v & keep[31:0];
        end
        send_op(MODE_PUSH_BITS, v, 6'(n), 10'($urandom));
        track_bits(n);
    endtask

    task automatic push_word_shaped();
        int unsigned start;
        start = (fill_est + 7) / 8;
        send_op(MODE_PUSH_WORD, $urandom, 6'($urandom), 10'($urandom));
        if (start + 4 <= BUFFER_BYTES) fill_est = (start + 4) * 8;
    endtask

    task automatic send_clear();
        send_op(MODE_CLEAR, $urandom, 6'($urandom), 10'($urandom));
        fill_est = 0;
    endtask

    // mostly reads inside or just past the used bytes, sometimes anywhere
    task automatic read_shaped();
        int unsigned used;
        int unsigned addr;
        used = (fill_est + 7) / 8;
        if (used > 0 && $urandom_range(4) != 0) begin
            addr = $urandom_range((used + 1 < BUFFER_BYTES) ? used + 1 : BUFFER_BYTES - 1);
        end else begin
            addr = $urandom_range(BUFFER_BYTES - 1);
        end
        send_op(MODE_READ, $urandom, 6'($urandom), 10'(addr));
    endtask

    // short runs that each start from a cleared store
    task automatic run_mixed(input int unsigned n_items);
        int unsigned stop_at;
        int unsigned run_len;
        int unsigned pick;
        stop_at = sent_items + n_items;
        while (sent_items < stop_at) begin
            send_clear();
            run_len = $urandom_range(30, 5);
            repeat (run_len) begin
                pick = $urandom_range(99);
                if (pick < 40) begin
                    push_shaped(1, 32);
                end else if (pick < 52) begin
                    // raw push with a random value and count, sometimes too wide for it
                    send_op(MODE_PUSH_BITS, $urandom, 6'($urandom_range(63)), 10'($urandom));
                end else if (pick < 68) begin
                    push_word_shaped();
                end else if (pick < 95) begin
                    read_shaped();
                end else begin
                    send_clear();
                end
            end
        end
    endtask

    // fill the whole store with wide pushes and words, then push past the end
    task automatic run_fill();
        int unsigned pick;
        send_clear();
        while (fill_est < CAP_BITS) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                push_shaped(32, 32);
            end else if (pick < 68) begin
                // counts above 32 act as 32
                send_op(MODE_PUSH_BITS, $urandom, 6'($urandom_range(63, 33)), 10'($urandom));
                track_bits(32);
            end else if (pick < 88) begin
                push_word_shaped();
            end else if (pick < 95) begin
                push_shaped(1, 31);
            end else begin
                read_shaped();
            end
        end
        // store full: every push kind now overflows
        repeat (3) push_shaped(1, 32);
        repeat (2) push_word_shaped();
        for (int a = BUFFER_BYTES - 4; a < BUFFER_BYTES; a++)
            send_op(MODE_READ, $urandom, 6'($urandom), 10'(a));
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part, no idling
        send_op(MODE_READ,      32'h0,        6'd0,  10'd0);      // empty store
        send_op(MODE_PUSH_BITS, 32'h1,        6'd1,  10'd0);
        send_op(MODE_PUSH_BITS, 32'h0,        6'd0,  10'd0);      // zero count appends nothing
        send_op(MODE_PUSH_BITS, 32'h5,        6'd0,  10'd0);      // zero count, value too wide
        send_op(MODE_PUSH_BITS, 32'h8,        6'd3,  10'd0);      // too wide
        send_op(MODE_PUSH_BITS, 32'h8000_0005, 6'd4, 10'd0);      // negative, low bits taken
        send_op(MODE_PUSH_WORD, 32'hDEAD_BEEF, 6'd0, 10'd0);      // skips padding bits
        send_op(MODE_PUSH_BITS, 32'hFFFF_FFFF, 6'd32, 10'd0);
        send_op(MODE_PUSH_BITS, 32'h1234_5678, 6'd63, 10'd0);     // count above 32
        send_op(MODE_PUSH_BITS, 32'h0,        6'd32, 10'd0);
        send_op(MODE_PUSH_BITS, 32'h1F,       6'd5,  10'd0);
        send_op(MODE_PUSH_BITS, 32'h8000_0000, 6'd32, 10'd0);
        send_op(MODE_PUSH_WORD, 32'h0,        6'd0,  10'd0);
        send_op(MODE_PUSH_WORD, 32'hFFFF_FFFF, 6'd0, 10'd0);
        for (int a = 0; a < 6; a++)
            send_op(MODE_READ, 32'h0, 6'd0, 10'(a));
        send_op(MODE_READ,      32'h0,        6'd0,  10'd1023);   // far past used length
        send_op(MODE_CLEAR,     32'hFFFF_FFFF, 6'd63, 10'd1023);
        send_op(MODE_READ,      32'h0,        6'd0,  10'd0);      // read after clear
        send_op(MODE_PUSH_BITS, 32'h7F,       6'd7,  10'd0);
        send_op(MODE_READ,      32'h0,        6'd0,  10'd0);

        // random part, one idle pattern per phase
        run_mixed(MIXED_PER_PHASE);

        send_idle_pct = 64;
        run_mixed(MIXED_PER_PHASE);

        send_idle_pct = 0;
        stall_pct     = 64;
        run_mixed(MIXED_PER_PHASE);

        send_idle_pct = 31;
        stall_pct     = 31;
        run_mixed(MIXED_PER_PHASE);
        run_fill();

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (replies_owed != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("[lsb_first_bit_packer_top] OK");
        end else begin
            $display("[lsb_first_bit_packer_top] ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/lbp_pkg.sv
rtl/lbp_ctrl.sv
rtl/lbp_datapath.sv
rtl/lsb_first_bit_packer_top.sv
sim/lsb_first_bit_packer_checker.sv
sim/lsb_first_bit_packer_top_test.sv
